// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/pbw_pkg.sv -----
// Package with result codes and register addresses of the wire field scanner.
package pbw_pkg;

	localparam int unsigned FIELD_BITS = 29;

	typedef enum logic [1:0] {
		KIND_SCALAR  = 2'd0,
		KIND_LENGTH  = 2'd1,
		KIND_PAYLOAD = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_WIRE_TYPE = 3'd1,
		ERR_VARINT    = 3'd2,
		ERR_TOO_LARGE = 3'd3,
		ERR_TRUNCATED = 3'd4
	} err_t;

	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LEN     = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	localparam logic [1:0] REG_SKIP_ADDR = 2'd0;

endpackage

// ----- rtl/pbw_if.sv -----
// Valid/ready channel interfaces for message bytes and scan results.
interface pbw_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       message_end;

	modport source (output valid, data_byte, message_end, input ready);
	modport sink (input valid, data_byte, message_end, output ready);
endinterface

interface pbw_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [28:0]        field_number;
	logic [2:0]         wire_type;
	logic [63:0]        raw_value;
	logic signed [63:0] signed_value;
	logic               last_payload;
	logic [2:0]         error_code;

	modport source (output valid, kind, field_number, wire_type, raw_value, signed_value,
		last_payload, error_code, input ready);
	modport sink (input valid, kind, field_number, wire_type, raw_value, signed_value,
		last_payload, error_code, output ready);
endinterface

// ----- rtl/protobuf_wire_field_scanner_top.sv -----
// Top level of the protocol-buffer wire field scanner.
// A result appears in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the decode step is one pass of logic from state to register.
// A byte is taken whenever the output register is empty or its result is taken that cycle.
// Reset (arst_n low, asynchronous) returns to expecting a tag, clears skip_q and
// the output valid.
`include "assert_macros.svh"

module protobuf_wire_field_scanner_top
	import pbw_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	pbw_byte_if.sink     src,
	pbw_result_if.source res,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	typedef enum logic [2:0] {
		PH_TAG,
		PH_VARINT,
		PH_FIXED,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_DRAIN
	} phase_t;

	phase_t                   phase_q, phase_d;
	logic [63:0]              acc_q, acc_d;
	logic [3:0]               cnt_q, cnt_d;
	logic [FIELD_BITS-1:0]    field_q, field_d;
	logic [2:0]               wt_q, wt_d;
	logic [LENGTH_BITS-1:0]   rem_q, rem_d;
	logic                     skip_q;

	logic                     out_valid_q;
	logic [1:0]               kind_q;
	logic [FIELD_BITS-1:0]    field_num_q;
	logic [2:0]               out_wt_q;
	logic [63:0]              raw_q;
	logic [63:0]              sval_q;
	logic                     last_q;
	logic [2:0]               err_code_q;

	logic                     accept;
	logic                     cfg_wr;

	// varint and fixed byte merge
	logic [3:0]               kv;
	logic [5:0]               vshift;
	logic [5:0]               fshift;
	logic [63:0]              acc_v;
	logic [63:0]              acc_f;
	logic                     v_cont;
	logic                     v_long;
	logic [2:0]               fk_next;
	logic                     fix_done;
	logic                     len_big;
	logic [LENGTH_BITS-1:0]   rem_dec;

	// result of this byte
	logic                     emit;
	logic [1:0]               kind_d;
	logic [FIELD_BITS-1:0]    fnum_d;
	logic [2:0]               owt_d;
	logic [63:0]              raw_d;
	logic [63:0]              sval_d;
	logic                     last_d;
	err_t                     err_d;

	assign accept = src.valid && src.ready;
	assign src.ready = !out_valid_q || res.ready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr == REG_SKIP_ADDR) ? {31'd0, skip_q} : 32'd0;

	assign kv = (cnt_q > 4'd9) ? 4'd9 : cnt_q;
	assign vshift = {2'b00, kv} * 6'd7;
	assign acc_v = acc_q | ({57'd0, src.data_byte[6:0]} << vshift);
	assign v_cont = src.data_byte[7];
	assign v_long = v_cont && (kv >= 4'd9);

	assign fshift = {cnt_q[2:0], 3'b000};
	assign acc_f = acc_q | ({56'd0, src.data_byte} << fshift);
	assign fk_next = cnt_q[2:0] + 3'd1;
	// fixed64 completes when the byte index wraps to zero
	assign fix_done = (wt_q == WT_FIXED64) ? (fk_next == 3'd0) : (fk_next == 3'd4);

	assign rem_dec = rem_q - LENGTH_BITS'(1);

	generate
		if (LENGTH_BITS < 64) begin : g_len_chk
			assign len_big = |acc_v[63:LENGTH_BITS];
		end else begin : g_len_full
			assign len_big = 1'b0;
		end
	endgenerate

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		field_d = field_q;
		wt_d    = wt_q;
		rem_d   = rem_q;
		emit    = 1'b0;
		kind_d  = KIND_SCALAR;
		fnum_d  = field_q;
		owt_d   = wt_q;
		raw_d   = 64'd0;
		sval_d  = 64'd0;
		last_d  = 1'b0;
		err_d   = ERR_NONE;

		unique case (phase_q)
			PH_TAG: begin
				if (v_long) begin
					err_d = ERR_VARINT;
				end else if (v_cont) begin
					acc_d = acc_v;
					cnt_d = kv + 4'd1;
				end else begin
					acc_d = 64'd0;
					cnt_d = 4'd0;
					if (|acc_v[63:32]) begin
						err_d = ERR_TOO_LARGE;
					end else if (acc_v[2:0] != WT_VARINT && acc_v[2:0] != WT_FIXED64 &&
						acc_v[2:0] != WT_LEN && acc_v[2:0] != WT_FIXED32) begin
						err_d = ERR_WIRE_TYPE;
					end else begin
						field_d = acc_v[31:3];
						wt_d    = acc_v[2:0];
						if (acc_v[2:0] == WT_VARINT) begin
							phase_d = PH_VARINT;
						end else if (acc_v[2:0] == WT_LEN) begin
							phase_d = PH_LENGTH;
						end else begin
							phase_d = PH_FIXED;
						end
					end
				end
			end
			PH_VARINT: begin
				if (v_long) begin
					err_d = ERR_VARINT;
				end else if (v_cont) begin
					acc_d = acc_v;
					cnt_d = kv + 4'd1;
				end else begin
					emit    = 1'b1;
					kind_d  = KIND_SCALAR;
					raw_d   = acc_v;
					sval_d  = {1'b0, acc_v[63:1]} ^ {64{acc_v[0]}};
					acc_d   = 64'd0;
					cnt_d   = 4'd0;
					phase_d = PH_TAG;
				end
			end
			PH_FIXED: begin
				if (fix_done) begin
					emit    = 1'b1;
					kind_d  = KIND_SCALAR;
					raw_d   = acc_f;
					acc_d   = 64'd0;
					cnt_d   = 4'd0;
					phase_d = PH_TAG;
				end else begin
					acc_d = acc_f;
					cnt_d = {1'b0, fk_next};
				end
			end
			PH_LENGTH: begin
				if (v_long) begin
					err_d = ERR_VARINT;
				end else if (v_cont) begin
					acc_d = acc_v;
					cnt_d = kv + 4'd1;
				end else begin
					acc_d = 64'd0;
					cnt_d = 4'd0;
					if (len_big) begin
						err_d = ERR_TOO_LARGE;
					end else begin
						emit    = 1'b1;
						kind_d  = KIND_LENGTH;
						raw_d   = acc_v;
						rem_d   = acc_v[LENGTH_BITS-1:0];
						phase_d = (acc_v == 64'd0) ? PH_TAG : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				rem_d  = rem_dec;
				emit   = !skip_q;
				kind_d = KIND_PAYLOAD;
				raw_d  = {56'd0, src.data_byte};
				last_d = (rem_dec == '0);
				if (rem_dec == '0) begin
					phase_d = PH_TAG;
				end
			end
			default: begin
				phase_d = PH_DRAIN;
			end
		endcase

		if (err_d != ERR_NONE) begin
			phase_d = PH_DRAIN;
			acc_d   = 64'd0;
			cnt_d   = 4'd0;
		end

		// message end replaces any header or payload result of an unfinished field
		if (src.message_end) begin
			if (err_d == ERR_NONE && phase_d != PH_TAG && phase_d != PH_DRAIN) begin
				err_d = ERR_TRUNCATED;
			end
			phase_d = PH_TAG;
			acc_d   = 64'd0;
			cnt_d   = 4'd0;
			field_d = '0;
			wt_d    = 3'd0;
			rem_d   = '0;
		end

		if (err_d != ERR_NONE) begin
			emit   = 1'b1;
			kind_d = KIND_ERROR;
			fnum_d = '0;
			owt_d  = 3'd0;
			raw_d  = 64'd0;
			sval_d = 64'd0;
			last_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TAG;
			acc_q       <= 64'd0;
			cnt_q       <= 4'd0;
			field_q     <= '0;
			wt_q        <= 3'd0;
			rem_q       <= '0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && paddr == REG_SKIP_ADDR) begin
				skip_q <= pwdata[0];
			end
			if (accept) begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				cnt_q   <= cnt_d;
				field_q <= field_d;
				wt_q    <= wt_d;
				rem_q   <= rem_d;
			end
			if (accept && emit) begin
				out_valid_q <= 1'b1;
				kind_q      <= kind_d;
				field_num_q <= fnum_d;
				out_wt_q    <= owt_d;
				raw_q       <= raw_d;
				sval_q      <= sval_d;
				last_q      <= last_d;
				err_code_q  <= err_d;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid        = out_valid_q;
	assign res.kind         = kind_q;
	assign res.field_number = field_num_q;
	assign res.wire_type    = out_wt_q;
	assign res.raw_value    = raw_q;
	assign res.signed_value = sval_q;
	assign res.last_payload = last_q;
	assign res.error_code   = err_code_q;

	`ASSERT_IMP(a_err_clean, clk, arst_n, out_valid_q && kind_q == KIND_ERROR,
		field_num_q == '0 && raw_q == 64'd0 && err_code_q != ERR_NONE)
	`ASSERT_IMP(a_ok_no_code, clk, arst_n, out_valid_q && kind_q != KIND_ERROR,
		err_code_q == ERR_NONE)
	`ASSERT_IMP(a_payload_left, clk, arst_n, phase_q == PH_PAYLOAD, rem_q != '0)
	`ASSERT_NXT(a_end_clears, clk, arst_n, accept && src.message_end,
		phase_q == PH_TAG && acc_q == 64'd0 && cnt_q == 4'd0)

endmodule
